/* rtl/core/wia_pkg.sv */
// Package for the wide integer ALU: operation codes and the limb width.
// No dependencies.
package wia_pkg;

   localparam int unsigned LIMB_BITS = 64;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

endpackage

/* rtl/core/wia_addsub.sv */
// Shared add/subtract unit of the wide integer ALU, DATA_BITS wide, combinational.
// Depends on nothing; instantiated by wide_integer_alu_unit.
module wia_addsub #(
   parameter int unsigned DATA_BITS = 192
) (
   input  logic [DATA_BITS-1:0] x,
   input  logic [DATA_BITS-1:0] y,
   input  logic                 sub,
   output logic [DATA_BITS-1:0] sum,
   output logic                 carry
);

   logic [DATA_BITS:0] full;

   // subtract as x + ~y + 1; carry high means no borrow
   assign full  = {1'b0, x} + {1'b0, (sub ? ~y : y)} + {{DATA_BITS{1'b0}}, sub};
   assign sum   = full[DATA_BITS-1:0];
   assign carry = full[DATA_BITS];

endmodule

/* rtl/core/wide_integer_alu_unit.sv */
// Top level of the wide integer ALU: sequencer, operand registers, result register.
// Depends on wia_pkg and wia_addsub.
//
// Unsigned DATA_BITS-wide integer unit. A request carries two operands as three
// 64-bit limbs and an operation: add, subtract, multiply (all modulo
// 2^DATA_BITS) or divide giving quotient and remainder. Operand bits above
// DATA_BITS are ignored. One request is worked at a time. Add and subtract
// present the result in the cycle after acceptance. Multiply and divide run one
// shift-add or shift-subtract step per operand bit through the single shared
// adder before presenting the result. A new request is taken the cycle after
// the result is taken. A zero divisor returns a zero quotient, the dividend as
// remainder and div_by_zero, in the cycle after acceptance. req_stall is high
// while a request is in progress or its result is still held in the output
// register waiting to be taken.
module wide_integer_alu_unit #(
   parameter int unsigned DATA_BITS = 192
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [63:0] a_word0,
   input  logic [63:0] a_word1,
   input  logic [63:0] a_word2,
   input  logic [63:0] b_word0,
   input  logic [63:0] b_word1,
   input  logic [63:0] b_word2,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] r_word0,
   output logic [63:0] r_word1,
   output logic [63:0] r_word2,
   output logic [63:0] rem_word0,
   output logic [63:0] rem_word1,
   output logic [63:0] rem_word2,
   output logic        div_by_zero
);

   localparam int unsigned FULL_BITS = 3 * wia_pkg::LIMB_BITS;
   localparam int unsigned CNT_BITS  = $clog2(DATA_BITS + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } state_type;

   state_type                 state_ff,  state_in;
   wia_pkg::op_type           op_ff,     op_in;
   logic [DATA_BITS-1:0]      x_ff,      x_in;   // mul: shifted multiplicand; div: dividend
   logic [DATA_BITS-1:0]      y_ff,      y_in;   // mul: multiplier; div: divisor
   logic [DATA_BITS-1:0]      acc_ff,    acc_in; // mul: product; div: partial remainder
   logic [DATA_BITS-1:0]      quo_ff,    quo_in;
   logic [CNT_BITS-1:0]       cnt_ff,    cnt_in;
   logic                      rvalid_ff, rvalid_in;
   logic [FULL_BITS-1:0]      res_ff,    res_in;
   logic [FULL_BITS-1:0]      rem_ff,    rem_in;
   logic                      dz_ff,     dz_in;

   logic [FULL_BITS-1:0]      a_full, b_full;
   logic [DATA_BITS-1:0]      a_cut,  b_cut;
   logic [DATA_BITS-1:0]      add_x,  add_y, add_sum;
   logic                      add_sub, add_carry;
   logic [DATA_BITS-1:0]      rem_sh;
   logic                      rem_out;
   logic                      accept, deliver;

   assign a_full = {a_word2, a_word1, a_word0};
   assign b_full = {b_word2, b_word1, b_word0};
   assign a_cut  = a_full[DATA_BITS-1:0];
   assign b_cut  = b_full[DATA_BITS-1:0];

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign deliver   = rvalid_ff && !rsp_stall;

   // restoring division: shift in the next dividend bit
   assign rem_sh  = {acc_ff[DATA_BITS-2:0], x_ff[DATA_BITS-1]};
   assign rem_out = acc_ff[DATA_BITS-1];

   // operand selection for the one shared adder
   always_comb begin
      add_x   = acc_ff;
      add_y   = x_ff;
      add_sub = 1'b0;
      if (state_ff == ST_IDLE) begin
         add_x   = a_cut;
         add_y   = b_cut;
         add_sub = (wia_pkg::op_type'(req_type) == wia_pkg::OP_SUB);
      end else if (op_ff == wia_pkg::OP_DIV) begin
         add_x   = rem_sh;
         add_y   = y_ff;
         add_sub = 1'b1;
      end
   end

   wia_addsub #(
      .DATA_BITS (DATA_BITS)
   ) u_addsub (
      .x     (add_x),
      .y     (add_y),
      .sub   (add_sub),
      .sum   (add_sum),
      .carry (add_carry)
   );

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      acc_in    = acc_ff;
      quo_in    = quo_ff;
      cnt_in    = cnt_ff;
      rvalid_in = rvalid_ff;
      res_in    = res_ff;
      rem_in    = rem_ff;
      dz_in     = dz_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in  = wia_pkg::op_type'(req_type);
               x_in   = a_cut;
               y_in   = b_cut;
               acc_in = '0;
               quo_in = '0;
               cnt_in = CNT_BITS'(DATA_BITS);
               rem_in = '0;
               dz_in  = 1'b0;
               res_in = '0;
               unique case (wia_pkg::op_type'(req_type))
                  wia_pkg::OP_ADD, wia_pkg::OP_SUB: begin
                     res_in[DATA_BITS-1:0] = add_sum;
                     rvalid_in             = 1'b1;
                     state_in              = ST_DONE;
                  end
                  wia_pkg::OP_DIV: begin
                     if (b_cut == '0) begin
                        rem_in[DATA_BITS-1:0] = a_cut;
                        dz_in                 = 1'b1;
                        rvalid_in             = 1'b1;
                        state_in              = ST_DONE;
                     end else begin
                        state_in = ST_RUN;
                     end
                  end
                  default: state_in = ST_RUN;
               endcase
            end
         end
         ST_RUN: begin
            cnt_in = cnt_ff - CNT_BITS'(1);
            if (op_ff == wia_pkg::OP_MUL) begin
               if (y_ff[0]) begin
                  acc_in = add_sum;
               end
               x_in = {x_ff[DATA_BITS-2:0], 1'b0};
               y_in = {1'b0, y_ff[DATA_BITS-1:1]};
            end else begin
               x_in = {x_ff[DATA_BITS-2:0], 1'b0};
               if (rem_out || add_carry) begin
                  acc_in = add_sum;
                  quo_in = {quo_ff[DATA_BITS-2:0], 1'b1};
               end else begin
                  acc_in = rem_sh;
                  quo_in = {quo_ff[DATA_BITS-2:0], 1'b0};
               end
            end
            if (cnt_ff == CNT_BITS'(1)) begin
               res_in = '0;
               rem_in = '0;
               if (op_ff == wia_pkg::OP_MUL) begin
                  res_in[DATA_BITS-1:0] = acc_in;
               end else begin
                  res_in[DATA_BITS-1:0] = quo_in;
                  rem_in[DATA_BITS-1:0] = acc_in;
               end
               rvalid_in = 1'b1;
               state_in  = ST_DONE;
            end
         end
         ST_DONE: begin
            if (deliver) begin
               rvalid_in = 1'b0;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rvalid_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         rvalid_ff <= rvalid_in;
         cnt_ff    <= cnt_in;
      end
      op_ff  <= op_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      acc_ff <= acc_in;
      quo_ff <= quo_in;
      res_ff <= res_in;
      rem_ff <= rem_in;
      dz_ff  <= dz_in;
   end

   assign rsp_valid   = rvalid_ff;
   assign r_word0     = res_ff[63:0];
   assign r_word1     = res_ff[127:64];
   assign r_word2     = res_ff[191:128];
   assign rem_word0   = rem_ff[63:0];
   assign rem_word1   = rem_ff[127:64];
   assign rem_word2   = rem_ff[191:128];
   assign div_by_zero = dz_ff;

   // result valid exactly while the sequencer sits in DONE
   a_valid_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid == (state_ff == ST_DONE))
      else $error("rsp_valid out of step with sequencer");

   // the step counter only runs down while iterating
   a_cnt_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (cnt_ff != '0))
      else $error("iteration counter exhausted in RUN");

   // flag only on a divide
   a_dz_div: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && div_by_zero) |-> (op_ff == wia_pkg::OP_DIV))
      else $error("div_by_zero on non-divide");

   // a delivered result frees the unit next cycle
   a_free: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall) |=> !req_stall)
      else $error("unit not freed after delivery");

endmodule
